[src/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// Shared constants, register indexes and the result word type of the
// ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int TimerBits   = 18;
	localparam int TrigBits    = 8;
	localparam int TimeoutBits = 18;
	localparam int SpeedBits   = 16;
	localparam int DistBits    = 16;
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 18;
	localparam int CmpBits     = (TimerBits > TimeoutBits) ? TimerBits : TimeoutBits;
	localparam int ProdBits    = TimerBits + SpeedBits + 1;

	localparam logic [CfgIdxBits-1:0] CfgTriggerTicks = 2'd0;
	localparam logic [CfgIdxBits-1:0] CfgTimeoutTicks = 2'd1;
	localparam logic [CfgIdxBits-1:0] CfgHalfSpeed    = 2'd2;

	localparam logic [TrigBits-1:0]    TrigTicksReset = 8'd10;
	localparam logic [TimeoutBits-1:0] TimeoutReset   = 18'd150000;
	localparam logic [SpeedBits-1:0]   HalfSpeedReset = 16'd11141;

	typedef struct packed {
		logic [TrigBits-1:0]    trigger_ticks;
		logic [TimeoutBits-1:0] timeout_ticks;
		logic [SpeedBits-1:0]   half_speed_q16;
	} cfg_t;

	typedef struct packed {
		logic                trigger_level;
		logic                done_res;
		logic                status;
		logic [DistBits-1:0] distance_mm;
		logic                busy_res;
	} res_t;

endpackage

[src/uer_cfg.sv]
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file: trigger length, timeout and Q16 scale.
// ----------------------------------------------------------------------------
module uer_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [uer_pkg::CfgIdxBits-1:0]     wr_index,
	input  logic [uer_pkg::CfgDataBits-1:0]    wr_data,
	output uer_pkg::cfg_t                      cfg
);

	uer_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks  <= uer_pkg::TrigTicksReset;
			cfg_q.timeout_ticks  <= uer_pkg::TimeoutReset;
			cfg_q.half_speed_q16 <= uer_pkg::HalfSpeedReset;
		end else if (wr_en) begin
			case (wr_index)
				uer_pkg::CfgTriggerTicks: begin
					cfg_q.trigger_ticks <= wr_data[uer_pkg::TrigBits-1:0];
				end
				uer_pkg::CfgTimeoutTicks: begin
					cfg_q.timeout_ticks <= wr_data[uer_pkg::TimeoutBits-1:0];
				end
				uer_pkg::CfgHalfSpeed: begin
					cfg_q.half_speed_q16 <= wr_data[uer_pkg::SpeedBits-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/uer_core.sv]
// ----------------------------------------------------------------------------
// uer_core
// Measurement state and per-tick update: trigger pulse, timeout, echo edges
// and distance scaling. State advances on step.
// ----------------------------------------------------------------------------
module uer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          echo_level,
	input  logic          start_request,
	input  uer_pkg::cfg_t cfg,
	output uer_pkg::res_t res
);

	logic                                active_q;
	logic [uer_pkg::TimerBits-1:0]       elapsed_q;
	logic [uer_pkg::TrigBits-1:0]        trig_cnt_q;
	logic                                rise_q;
	logic [uer_pkg::TimerBits-1:0]       width_q;
	logic                                last_echo_q;

	logic                                active_d;
	logic [uer_pkg::TimerBits-1:0]       elapsed_d;
	logic [uer_pkg::TrigBits-1:0]        trig_cnt_d;
	logic                                rise_d;
	logic [uer_pkg::TimerBits-1:0]       width_d;

	logic [uer_pkg::TimerBits-1:0]       elapsed_t;
	logic [uer_pkg::TimerBits-1:0]       width_t;
	logic [uer_pkg::TrigBits-1:0]        trig_cnt_t;
	logic                                start_tick;
	logic                                trig;
	logic                                timeout;
	logic                                rise_edge;
	logic                                fall_edge;
	logic [uer_pkg::ProdBits-1:0]        prod;
	logic [uer_pkg::TimerBits:0]         scaled;
	logic [uer_pkg::DistBits-1:0]        dist_sat;

	always_comb begin
		start_tick = 1'b0;
		elapsed_t  = elapsed_q;
		width_t    = width_q;
		trig_cnt_t = trig_cnt_q;
		rise_d     = rise_q;
		active_d   = active_q;
		if (active_q) begin
			elapsed_t = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
			if (rise_q) begin
				width_t = (&width_q) ? width_q : width_q + 1'b1;
			end
		end else if (start_request) begin
			start_tick = 1'b1;
			active_d   = 1'b1;
			elapsed_t  = '0;
			width_t    = '0;
			trig_cnt_t = cfg.trigger_ticks;
			rise_d     = 1'b0;
		end

		trig       = (trig_cnt_t != '0);
		trig_cnt_d = trig ? trig_cnt_t - 1'b1 : trig_cnt_t;

		prod     = uer_pkg::ProdBits'(width_t) * uer_pkg::ProdBits'(cfg.half_speed_q16)
			+ uer_pkg::ProdBits'(32768);
		scaled   = prod[uer_pkg::ProdBits-1:16];
		dist_sat = (scaled[uer_pkg::TimerBits:16] != '0) ? '1 : scaled[15:0];

		timeout   = uer_pkg::CmpBits'(elapsed_t) > uer_pkg::CmpBits'(cfg.timeout_ticks);
		rise_edge = echo_level && !last_echo_q;
		fall_edge = !echo_level && last_echo_q && rise_q;

		elapsed_d = elapsed_t;
		width_d   = width_t;

		res.trigger_level = trig;
		res.done_res      = 1'b0;
		res.status        = 1'b0;
		res.distance_mm   = '0;

		if (!start_tick && active_q) begin
			if (timeout) begin
				res.done_res = 1'b1;
				res.status   = 1'b1;
			end else if (rise_edge) begin
				rise_d  = 1'b1;
				width_d = '0;
			end else if (fall_edge) begin
				res.done_res    = 1'b1;
				res.distance_mm = dist_sat;
			end
			if (res.done_res) begin
				active_d   = 1'b0;
				rise_d     = 1'b0;
				width_d    = '0;
				elapsed_d  = '0;
				trig_cnt_d = '0;
			end
		end
		res.busy_res = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			elapsed_q   <= '0;
			trig_cnt_q  <= '0;
			rise_q      <= 1'b0;
			width_q     <= '0;
			last_echo_q <= 1'b0;
		end else if (step) begin
			active_q    <= active_d;
			elapsed_q   <= elapsed_d;
			trig_cnt_q  <= trig_cnt_d;
			rise_q      <= rise_d;
			width_q     <= width_d;
			last_echo_q <= echo_level;
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (elapsed_q == '0 && width_q == '0 && !rise_q && trig_cnt_q == '0))
		else $error("idle state not cleared");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> !active_q)
		else $error("block still active after a result");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res.status || res.distance_mm != '0) |-> res.done_res)
		else $error("status or distance without done");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !active_q && start_request) |=> active_q)
		else $error("start while idle did not begin a measurement");

endmodule

[src/ultrasonic_echo_ranger.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Time-of-flight echo ranger: one word per microsecond tick in, one result
// word per tick out.
// ----------------------------------------------------------------------------
// Takes one input word per clock while in_stall is low and returns one
// result word for every word. The word is captured in an input register,
// the measurement state and the distance (one 18x16 multiply with rounding
// and saturation) are computed combinationally from it, and the result
// lands in an output register; the state loop sets the rate of one word per
// cycle when the output is not stalled. Write the configuration registers
// only while no words are in flight.
module ultrasonic_echo_ranger (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            echo_level,
	input  logic                            start_request,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            trigger_level,
	output logic                            done_res,
	output logic                            status,
	output logic [uer_pkg::DistBits-1:0]    distance_mm,
	output logic                            busy_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [uer_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [uer_pkg::CfgDataBits-1:0] cfg_data
);

	uer_pkg::cfg_t cfg;
	uer_pkg::res_t res;
	uer_pkg::res_t res_s2;

	logic valid_s1;
	logic echo_s1;
	logic start_s1;
	logic valid_s2;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	uer_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uer_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.echo_level    (echo_s1),
		.start_request (start_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			echo_s1  <= echo_level;
			start_s1 <= start_request;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign trigger_level = res_s2.trigger_level;
	assign done_res      = res_s2.done_res;
	assign status        = res_s2.status;
	assign distance_mm   = res_s2.distance_mm;
	assign busy_res      = res_s2.busy_res;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced word missing from output register");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !advance)
		else $error("output overwritten while stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input word dropped");

endmodule
